/* rtl/core/dfac_pkg.sv */
package dfac_pkg;

  localparam int StateCountDef = 256;
  localparam int SymW          = 8;
  localparam int StW           = 8;
  // table entry: present flag over next state
  localparam int EntryW        = StW + 1;

  localparam logic [SymW-1:0] ChAt   = 8'h40;
  localparam logic [SymW-1:0] ChDot  = 8'h2E;
  localparam logic [SymW-1:0] ChLoA  = 8'h61;
  localparam logic [SymW-1:0] ChLoZ  = 8'h7A;
  localparam logic [SymW-1:0] ChDig0 = 8'h30;
  localparam logic [SymW-1:0] ChDig9 = 8'h39;

  typedef enum logic [1:0] {
    CmdWrTrans  = 2'd0,
    CmdSetFinal = 2'd1,
    CmdSymbol   = 2'd2,
    CmdEnd      = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]      command;
    logic [SymW-1:0] symbol;
    logic [StW-1:0]  from_state;
    logic [StW-1:0]  to_state;
    logic            final_value;
  } item_t;

  typedef struct packed {
    logic            we;
    logic            re;
    logic [StW-1:0]  state;
    logic [SymW-1:0] symbol;
    logic [StW-1:0]  next_state;
  } tbl_req_t;

  typedef struct packed {
    logic           we;
    logic           re;
    logic [StW-1:0] state;
    logic           final_value;
  } flag_req_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } verdict_t;

endpackage

/* rtl/core/dfac_if.sv */
interface dfac_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [dfac_pkg::SymW-1:0]  symbol;
  logic [dfac_pkg::StW-1:0]   from_state;
  logic [dfac_pkg::StW-1:0]   to_state;
  logic                       final_value;

  modport source (output valid, command, symbol, from_state, to_state, final_value,
                  input ready);
  modport sink   (input valid, command, symbol, from_state, to_state, final_value,
                  output ready);
endinterface

interface dfac_res_if;
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, accepted, input ready);
  modport sink   (input valid, accepted, output ready);
endinterface

interface dfac_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [dfac_pkg::StW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/dfac_trans_mem.sv */
module dfac_trans_mem #(
  parameter int StateCount = dfac_pkg::StateCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dfac_pkg::tbl_req_t          req_i,
  output logic                        busy_o,
  output logic [dfac_pkg::EntryW-1:0] rdata_o
);

  localparam int StateW = (StateCount > 1) ? $clog2(StateCount) : 1;
  localparam int ExtW   = (StateW > dfac_pkg::StW) ? StateW : dfac_pkg::StW;
  localparam int AddrW  = StateW + dfac_pkg::SymW;
  localparam int Depth  = StateCount * (2 ** dfac_pkg::SymW);

  logic [dfac_pkg::EntryW-1:0] mem_q [Depth];
  logic [dfac_pkg::EntryW-1:0] rdata_q;
  logic [AddrW-1:0]            clr_cnt_q, clr_cnt_d;
  logic                        busy_q, busy_d;
  logic [ExtW-1:0]             state_ext;
  logic [AddrW-1:0]            addr;

  assign state_ext = ExtW'(req_i.state);
  assign addr      = {state_ext[StateW-1:0], req_i.symbol};

  // sweep every entry to absent after reset
  always_comb begin
    busy_d    = busy_q;
    clr_cnt_d = clr_cnt_q;
    if (busy_q) begin
      if (clr_cnt_q == AddrW'(Depth - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      busy_q    <= busy_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (req_i.we) begin
      mem_q[addr] <= {1'b1, req_i.next_state};
    end
    if (req_i.re) begin
      rdata_q <= mem_q[addr];
    end
  end

  assign busy_o  = busy_q;
  assign rdata_o = rdata_q;

endmodule

/* rtl/core/dfac_flag_mem.sv */
module dfac_flag_mem #(
  parameter int StateCount = dfac_pkg::StateCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dfac_pkg::flag_req_t req_i,
  output logic                busy_o,
  output logic                rdata_o
);

  localparam int StateW = (StateCount > 1) ? $clog2(StateCount) : 1;
  localparam int ExtW   = (StateW > dfac_pkg::StW) ? StateW : dfac_pkg::StW;

  logic              mem_q [StateCount];
  logic              rdata_q;
  logic [StateW-1:0] clr_cnt_q, clr_cnt_d;
  logic              busy_q, busy_d;
  logic [ExtW-1:0]   state_ext;
  logic [StateW-1:0] addr;

  assign state_ext = ExtW'(req_i.state);
  assign addr      = state_ext[StateW-1:0];

  always_comb begin
    busy_d    = busy_q;
    clr_cnt_d = clr_cnt_q;
    if (busy_q) begin
      if (clr_cnt_q == StateW'(StateCount - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      busy_q    <= busy_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_cnt_q] <= 1'b0;
    end else if (req_i.we) begin
      mem_q[addr] <= req_i.final_value;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[addr];
    end
  end

  assign busy_o  = busy_q;
  assign rdata_o = rdata_q;

endmodule

/* rtl/core/dfac_walker.sv */
module dfac_walker #(
  parameter int StateCount = dfac_pkg::StateCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  dfac_pkg::item_t             item_i,
  input  logic                        cfg_we_i,
  input  logic [dfac_pkg::StW-1:0]    cfg_data_i,
  input  logic [dfac_pkg::EntryW-1:0] tbl_rdata_i,
  input  logic                        verdict_adv_i,
  output dfac_pkg::tbl_req_t          tbl_req_o,
  output dfac_pkg::flag_req_t         flag_req_o,
  output dfac_pkg::verdict_t          verdict_o
);

  localparam int PresentBit = dfac_pkg::EntryW - 1;

  logic [dfac_pkg::StW-1:0] start_q, start_d;
  logic [dfac_pkg::StW-1:0] cur_q, cur_d;
  logic                     dead_q, dead_d;
  logic                     at_q, at_d;
  logic                     dot_q, dot_d;
  logic                     bad_q, bad_d;
  logic                     instr_q, instr_d;
  logic                     step_q, step_d;
  dfac_pkg::verdict_t       verdict_q, verdict_d;

  logic                     eff_dead;
  logic [dfac_pkg::StW-1:0] eff_state;
  dfac_pkg::cmd_e           cmd;

  function automatic logic state_ok(input logic [dfac_pkg::StW-1:0] s);
    return {24'd0, s} < 32'(StateCount);
  endfunction

  assign cmd = dfac_pkg::cmd_e'(item_i.command);

  // fold in the lookup issued last cycle
  assign eff_dead  = dead_q | (step_q & ~tbl_rdata_i[PresentBit]);
  assign eff_state = (step_q && tbl_rdata_i[PresentBit]) ?
                     tbl_rdata_i[dfac_pkg::StW-1:0] : cur_q;

  always_comb begin
    start_d    = start_q;
    cur_d      = eff_state;
    dead_d     = eff_dead;
    at_d       = at_q;
    dot_d      = dot_q;
    bad_d      = bad_q;
    instr_d    = instr_q;
    step_d     = 1'b0;
    verdict_d  = verdict_q;
    tbl_req_o  = '0;
    flag_req_o = '0;

    if (verdict_adv_i) begin
      verdict_d.valid = 1'b0;
    end

    tbl_req_o.state       = item_i.from_state;
    tbl_req_o.symbol      = item_i.symbol;
    tbl_req_o.next_state  = item_i.to_state;
    flag_req_o.state      = item_i.from_state;
    flag_req_o.final_value = item_i.final_value;

    if (acc_i) begin
      case (cmd)
        dfac_pkg::CmdWrTrans: begin
          tbl_req_o.we = state_ok(item_i.from_state) && state_ok(item_i.to_state);
        end
        dfac_pkg::CmdSetFinal: begin
          flag_req_o.we = state_ok(item_i.from_state);
        end
        dfac_pkg::CmdSymbol: begin
          instr_d = 1'b1;
          if (item_i.symbol == dfac_pkg::ChAt) begin
            if (at_q) begin
              bad_d = 1'b1;
            end
            at_d = 1'b1;
          end else if (item_i.symbol == dfac_pkg::ChDot) begin
            if (!at_q) begin
              bad_d = 1'b1;
            end else begin
              dot_d = 1'b1;
            end
          end else if (!(item_i.symbol inside {[dfac_pkg::ChLoA:dfac_pkg::ChLoZ],
                                               [dfac_pkg::ChDig0:dfac_pkg::ChDig9]})) begin
            bad_d = 1'b1;
          end
          if (!eff_dead) begin
            if (state_ok(eff_state)) begin
              tbl_req_o.re    = 1'b1;
              tbl_req_o.state = eff_state;
              step_d          = 1'b1;
            end else begin
              dead_d = 1'b1;
            end
          end
        end
        dfac_pkg::CmdEnd: begin
          flag_req_o.re    = 1'b1;
          flag_req_o.state = eff_state;
          verdict_d.valid  = 1'b1;
          verdict_d.ok     = !bad_q && at_q && dot_q && !eff_dead && state_ok(eff_state);
          cur_d            = start_q;
          dead_d           = 1'b0;
          at_d             = 1'b0;
          dot_d            = 1'b0;
          bad_d            = 1'b0;
          instr_d          = 1'b0;
        end
        default: begin
          instr_d = instr_q;
        end
      endcase
    end

    // a new start state waits for the next string when one is under way
    if (cfg_we_i) begin
      start_d = cfg_data_i;
      if (!instr_q || (acc_i && cmd == dfac_pkg::CmdEnd)) begin
        cur_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= '0;
      cur_q     <= '0;
      dead_q    <= 1'b0;
      at_q      <= 1'b0;
      dot_q     <= 1'b0;
      bad_q     <= 1'b0;
      instr_q   <= 1'b0;
      step_q    <= 1'b0;
      verdict_q <= '0;
    end else begin
      start_q   <= start_d;
      cur_q     <= cur_d;
      dead_q    <= dead_d;
      at_q      <= at_d;
      dot_q     <= dot_d;
      bad_q     <= bad_d;
      instr_q   <= instr_d;
      step_q    <= step_d;
      verdict_q <= verdict_d;
    end
  end

  assign verdict_o = verdict_q;

endmodule

/* rtl/core/dfa_email_string_classifier.sv */
// Channel   Modport  Handshake      Payload
// in_i      sink     valid/ready    command, symbol, from_state, to_state, final_value
// cfg_i     sink     valid/ready    data (start_state)
// res_o     source   valid/ready    accepted
//
// One item per cycle: a symbol reads the transition memory at {state, byte} and the
// next symbol's address is taken from that read data in the following cycle.
// An end item reads the final-flag memory; its result goes to the verdict register and
// then to the output register. After reset a clearing pass sweeps every transition entry
// and final flag; cfg_i is always ready. in_i.ready stays low until the pass is done;
// after it, input stalls only when an end result waits behind a held output register.
module dfa_email_string_classifier #(
  parameter int STATE_COUNT = dfac_pkg::StateCountDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dfac_in_if.sink   in_i,
  dfac_cfg_if.sink  cfg_i,
  dfac_res_if.source res_o
);

  dfac_pkg::item_t                item;
  dfac_pkg::tbl_req_t             tbl_req;
  dfac_pkg::flag_req_t            flag_req;
  dfac_pkg::verdict_t             verdict;
  logic [dfac_pkg::EntryW-1:0]    tbl_rdata;
  logic                           flag_rdata;
  logic                           tbl_busy, flag_busy, busy;
  logic                           in_acc;
  logic                           verdict_adv;
  logic                           out_valid_q, out_valid_d;
  logic                           out_acc_q, out_acc_d;

  assign item.command     = in_i.command;
  assign item.symbol      = in_i.symbol;
  assign item.from_state  = in_i.from_state;
  assign item.to_state    = in_i.to_state;
  assign item.final_value = in_i.final_value;

  assign busy        = tbl_busy | flag_busy;
  assign verdict_adv = verdict.valid && (!out_valid_q || res_o.ready);
  assign in_i.ready  = !busy && (!verdict.valid || verdict_adv);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  dfac_walker #(
    .StateCount(STATE_COUNT)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (in_acc),
    .item_i       (item),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.data),
    .tbl_rdata_i  (tbl_rdata),
    .verdict_adv_i(verdict_adv),
    .tbl_req_o    (tbl_req),
    .flag_req_o   (flag_req),
    .verdict_o    (verdict)
  );

  dfac_trans_mem #(
    .StateCount(STATE_COUNT)
  ) u_trans_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .busy_o (tbl_busy),
    .rdata_o(tbl_rdata)
  );

  dfac_flag_mem #(
    .StateCount(STATE_COUNT)
  ) u_flag_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (flag_req),
    .busy_o (flag_busy),
    .rdata_o(flag_rdata)
  );

  // output register: hold until the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    out_acc_d   = out_acc_q;
    if (verdict_adv) begin
      out_valid_d = 1'b1;
      out_acc_d   = verdict.ok & flag_rdata;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_acc_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      out_acc_q   <= out_acc_d;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.accepted = out_acc_q;

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_i.ready)
    else $error("item accepted during memory clearing");

  a_end_makes_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.command == dfac_pkg::CmdEnd) |=> verdict.valid)
    else $error("end item produced no pending verdict");

  a_stuck_verdict_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (verdict.valid && out_valid_q && !res_o.ready) |-> !in_i.ready)
    else $error("input open while a verdict is blocked");

  a_verdict_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict_adv |=> out_valid_q)
    else $error("verdict lost on its way to the output register");

endmodule
